FILE: design/sfp_pkg.sv
// ---------------------------------------------------------------------------
// sfp_pkg: shared types and constants of the stateful packet filter
// Payload structs, action/list/cause codes, and the controller-datapath
// command and status bundles.
// ---------------------------------------------------------------------------
package sfp_pkg;

  localparam int unsigned RuleDepthDef = 16;
  localparam int unsigned PeerDepthDef = 16;

  localparam logic [31:0] WindowReset = 32'd60;
  localparam logic [31:0] LoopbackAddr = 32'd2130706433;
  localparam logic [31:0] CntMax = 32'hFFFF_FFFF;

  // action codes
  localparam logic [1:0] ActInbound = 2'd0;
  localparam logic [1:0] ActOutbound = 2'd1;
  localparam logic [1:0] ActRule = 2'd2;

  // rule list codes
  localparam logic [1:0] ListAllow = 2'd0;
  localparam logic [1:0] ListInDeny = 2'd1;
  localparam logic [1:0] ListOutDeny = 2'd2;
  localparam logic [1:0] ListNone = 2'd3;

  // cause codes
  localparam logic [2:0] CauseAllow = 3'd0;
  localparam logic [2:0] CauseInDeny = 3'd1;
  localparam logic [2:0] CausePeer = 3'd2;
  localparam logic [2:0] CauseNoMatch = 3'd3;
  localparam logic [2:0] CauseOutDeny = 3'd4;
  localparam logic [2:0] CausePass = 3'd5;
  localparam logic [2:0] CauseRule = 3'd6;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] peer_address;
    logic [7:0]  protocol_number;
    logic [15:0] dest_port;
    logic [31:0] now_seconds;
    logic [1:0]  rule_list;
    logic [3:0]  rule_slot;
    logic        rule_enable;
  } item_t;

  typedef struct packed {
    logic        verdict;
    logic [2:0]  cause;
    logic [31:0] hit_count;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic       latch;
    logic       load;
    logic       next_list;
    logic       pick;
    logic       inc;
    logic       wrule;
    logic       plook;
    logic       pinc;
    logic       age_clr;
    logic       age_step;
    logic       insert;
    logic       clean;
    logic       res_we;
    logic       res_verdict;
    logic [2:0] res_cause;
    logic       res_hit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] action;
    logic [1:0] list;
    logic       mvec_nz;
    logic       wild;
    logic       any;
    logic       in_hit;
    logic       out_found;
    logic       pfree;
    logic       age_last;
  } sts_t;

endpackage

FILE: design/sfp_ctrl.sv
// ---------------------------------------------------------------------------
// sfp_ctrl: sequencing state machine
// Steps through the rule scans, peer lookup, insert and cleanup for one
// transfer and raises the result strobe.
// ---------------------------------------------------------------------------
module sfp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [1:0]     start_action_i,
  input  sfp_pkg::sts_t  sts_i,
  output sfp_pkg::cmd_t  cmd_o,
  output logic           busy_o,
  output logic           done_o
);
  import sfp_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_LOAD  = 12'b0000_0000_0010,
    S_PICK  = 12'b0000_0000_0100,
    S_INC   = 12'b0000_0000_1000,
    S_LEND  = 12'b0000_0001_0000,
    S_PLOOK = 12'b0000_0010_0000,
    S_PINC  = 12'b0000_0100_0000,
    S_PEND  = 12'b0000_1000_0000,
    S_AGE   = 12'b0001_0000_0000,
    S_INS   = 12'b0010_0000_0000,
    S_CLEAN = 12'b0100_0000_0000,
    S_DONE  = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          if (start_action_i == ActInbound || start_action_i == ActOutbound) begin
            state_d = S_LOAD;
          end else begin
            if (start_action_i == ActRule) cmd_o.wrule = 1'b0;
            cmd_o.res_we = 1'b1;
            cmd_o.res_cause = CauseRule;
            state_d = (start_action_i == ActRule) ? S_INS : S_DONE;
          end
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d = S_PICK;
      end
      S_PICK: begin
        if (sts_i.mvec_nz) begin
          cmd_o.pick = 1'b1;
          state_d = S_INC;
        end else begin
          state_d = S_LEND;
        end
      end
      S_INC: begin
        cmd_o.inc = 1'b1;
        state_d = sts_i.wild ? S_LEND : S_PICK;
      end
      S_LEND: begin
        if (sts_i.any) begin
          cmd_o.res_we = 1'b1;
          cmd_o.res_hit = 1'b1;
          case (sts_i.list)
            ListAllow: cmd_o.res_cause = CauseAllow;
            ListInDeny: begin
              cmd_o.res_cause = CauseInDeny;
              cmd_o.res_verdict = 1'b1;
            end
            default: begin
              cmd_o.res_cause = CauseOutDeny;
              cmd_o.res_verdict = 1'b1;
            end
          endcase
          state_d = S_DONE;
        end else if (sts_i.list == ListAllow) begin
          cmd_o.next_list = 1'b1;
          state_d = S_LOAD;
        end else begin
          state_d = S_PLOOK;
        end
      end
      S_PLOOK: begin
        if (sts_i.action == ActInbound) begin
          if (sts_i.in_hit) begin
            cmd_o.plook = 1'b1;
            state_d = S_PINC;
          end else begin
            cmd_o.res_we = 1'b1;
            cmd_o.res_verdict = 1'b1;
            cmd_o.res_cause = CauseNoMatch;
            state_d = S_DONE;
          end
        end else if (sts_i.out_found) begin
          cmd_o.plook = 1'b1;
          state_d = S_PINC;
        end else if (sts_i.pfree) begin
          state_d = S_INS;
        end else begin
          cmd_o.age_clr = 1'b1;
          state_d = S_AGE;
        end
      end
      S_PINC: begin
        cmd_o.pinc = 1'b1;
        state_d = (sts_i.action == ActInbound) ? S_PEND : S_CLEAN;
      end
      S_PEND: begin
        cmd_o.res_we = 1'b1;
        cmd_o.res_hit = 1'b1;
        cmd_o.res_cause = CausePeer;
        state_d = S_DONE;
      end
      S_AGE: begin
        cmd_o.age_step = 1'b1;
        if (sts_i.age_last) state_d = S_INS;
      end
      S_INS: begin
        // rule writes pass through here as well
        if (sts_i.action == ActRule) begin
          cmd_o.wrule = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.insert = 1'b1;
          state_d = S_CLEAN;
        end
      end
      S_CLEAN: begin
        cmd_o.clean = 1'b1;
        cmd_o.res_we = 1'b1;
        cmd_o.res_hit = 1'b1;
        cmd_o.res_cause = CausePass;
        state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

  // checks
  a_done_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |=> state_q == S_IDLE)
    else $error("result strobe not followed by idle");
  a_start_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start_i) |=> state_q != S_IDLE)
    else $error("accepted transfer did not start work");
  a_inc_after_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INC |-> $past(state_q) == S_PICK)
    else $error("counter update without a pick");
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two results for one transfer");

endmodule

FILE: design/sfp_datapath.sv
// ---------------------------------------------------------------------------
// sfp_datapath: rule lists, hit counters and peer table
// Parallel rule and peer compares, counter memories, age search and result
// register, driven by the controller commands.
// ---------------------------------------------------------------------------
module sfp_datapath #(
  parameter int unsigned RULE_DEPTH = sfp_pkg::RuleDepthDef,
  parameter int unsigned PEER_DEPTH = sfp_pkg::PeerDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sfp_pkg::item_t   item_i,
  input  logic [31:0]      window_i,
  input  sfp_pkg::cmd_t    cmd_i,
  output sfp_pkg::sts_t    sts_o,
  output sfp_pkg::result_t result_o
);
  import sfp_pkg::*;

  localparam int unsigned RIW = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
  localparam int unsigned PIW = (PEER_DEPTH > 1) ? $clog2(PEER_DEPTH) : 1;
  localparam int unsigned CNT_N = 3 * RULE_DEPTH;
  localparam int unsigned CW = $clog2(CNT_N);

  // latched item and scan state
  item_t             item_q;
  logic [1:0]        list_q;
  logic [RULE_DEPTH-1:0] mvec_q, wvec_q;
  logic              wild_q, any_q;
  logic [31:0]       hit_q;
  result_t           res_q;

  // rule storage
  logic              rule_v_q     [3][RULE_DEPTH];
  logic [31:0]       rule_addr_q  [3][RULE_DEPTH];
  logic [7:0]        rule_proto_q [3][RULE_DEPTH];
  logic [15:0]       rule_port_q  [3][RULE_DEPTH];

  // rule hit counters
  logic [31:0]       rcnt_mem [CNT_N];
  logic [CNT_N-1:0]  rok_q;
  logic [CW-1:0]     rd_addr_q;
  logic [31:0]       rd_data_q;
  logic              rd_ok_q;

  // peer table
  logic [PEER_DEPTH-1:0] pv_q, pok_q;
  logic [31:0]       paddr_q  [PEER_DEPTH];
  logic [31:0]       pstamp_q [PEER_DEPTH];
  logic [31:0]       sent_mem [PEER_DEPTH];
  logic [31:0]       recv_mem [PEER_DEPTH];
  logic [PIW-1:0]    pidx_q;
  logic [31:0]       sent_rd_q, recv_rd_q;
  logic              prd_ok_q;

  // age search
  logic [PIW-1:0]    acnt_q, apick_q;
  logic [31:0]       best_q;

  function automatic logic [RIW-1:0] low_r(input logic [RULE_DEPTH-1:0] v);
    logic [RIW-1:0] r;
    r = '0;
    for (int i = RULE_DEPTH - 1; i >= 0; i--) begin
      if (v[i]) r = RIW'(i);
    end
    return r;
  endfunction

  function automatic logic [PIW-1:0] low_p(input logic [PEER_DEPTH-1:0] v);
    logic [PIW-1:0] r;
    r = '0;
    for (int i = PEER_DEPTH - 1; i >= 0; i--) begin
      if (v[i]) r = PIW'(i);
    end
    return r;
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    return (c == CntMax) ? c : c + 32'd1;
  endfunction

  // rule compare over the selected list
  logic [RULE_DEPTH-1:0] rmatch, rwild;
  always_comb begin
    for (int i = 0; i < RULE_DEPTH; i++) begin
      logic        v;
      logic [31:0] a;
      logic [7:0]  p;
      logic [15:0] pt;
      case (list_q)
        ListAllow: begin
          v = rule_v_q[0][i]; a = rule_addr_q[0][i];
          p = rule_proto_q[0][i]; pt = rule_port_q[0][i];
        end
        ListInDeny: begin
          v = rule_v_q[1][i]; a = rule_addr_q[1][i];
          p = rule_proto_q[1][i]; pt = rule_port_q[1][i];
        end
        default: begin
          v = rule_v_q[2][i]; a = rule_addr_q[2][i];
          p = rule_proto_q[2][i]; pt = rule_port_q[2][i];
        end
      endcase
      rwild[i] = (p == 8'd0) && (pt == 16'd0);
      rmatch[i] = v && (a == item_q.peer_address) &&
                  (rwild[i] || ((p != 8'd0) && (p == item_q.protocol_number) &&
                   ((pt == 16'd0) || (pt == item_q.dest_port))));
    end
  end

  // peer compare and age
  logic [PEER_DEPTH-1:0] pfnd, pin, pexp;
  logic [31:0]           page [PEER_DEPTH];
  always_comb begin
    for (int i = 0; i < PEER_DEPTH; i++) begin
      page[i] = item_q.now_seconds - pstamp_q[i];
      pfnd[i] = pv_q[i] && (paddr_q[i] == item_q.peer_address);
      pin[i]  = pfnd[i] && (page[i] <= window_i);
      pexp[i] = pv_q[i] && (page[i] > window_i);
    end
  end

  logic [RIW-1:0] rpick;
  logic [CW-1:0]  rcnt_addr, rw_addr;
  logic [31:0]    rinc, pinc_v, acur;
  logic [PIW-1:0] plook_idx, ins_idx;
  logic [RIW-1:0] wslot;
  logic           wvalid;

  assign rpick = low_r(mvec_q);
  assign rcnt_addr = CW'(int'(list_q) * RULE_DEPTH + int'(rpick));
  assign wslot = RIW'(item_q.rule_slot);
  assign wvalid = (item_q.rule_list != ListNone) && (int'(item_q.rule_slot) < RULE_DEPTH);
  assign rw_addr = CW'(int'(item_q.rule_list) * RULE_DEPTH + int'(wslot));
  assign rinc = sat_inc(rd_ok_q ? rd_data_q : 32'd0);
  assign pinc_v = sat_inc(prd_ok_q ? ((item_q.action == ActOutbound) ? sent_rd_q : recv_rd_q)
                                   : 32'd0);
  assign plook_idx = low_p((item_q.action == ActOutbound) ? pfnd : pin);
  assign ins_idx = (~&pv_q) ? low_p(~pv_q) : apick_q;
  assign acur = page[acnt_q];

  // item, scan and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_q <= ListAllow;
      any_q  <= 1'b0;
      wild_q <= 1'b0;
      mvec_q <= '0;
      wvec_q <= '0;
      hit_q  <= '0;
      res_q  <= '0;
    end else begin
      if (cmd_i.latch) begin
        list_q <= (item_i.action == ActOutbound) ? ListOutDeny : ListAllow;
        any_q  <= 1'b0;
      end
      if (cmd_i.next_list) list_q <= ListInDeny;
      if (cmd_i.load) begin
        mvec_q <= rmatch;
        wvec_q <= rwild & rmatch;
      end
      if (cmd_i.pick) begin
        mvec_q[rpick] <= 1'b0;
        wild_q <= wvec_q[rpick];
      end
      if (cmd_i.inc) begin
        hit_q <= rinc;
        any_q <= 1'b1;
      end
      if (cmd_i.pinc) hit_q <= pinc_v;
      if (cmd_i.insert) hit_q <= 32'd1;
      if (cmd_i.res_we) begin
        res_q.verdict <= cmd_i.res_verdict;
        res_q.cause <= cmd_i.res_cause;
        res_q.hit_count <= cmd_i.res_hit ? hit_q : 32'd0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) item_q <= item_i;
  end

  // rule entries
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < 3; l++) begin
        for (int i = 0; i < RULE_DEPTH; i++) begin
          rule_v_q[l][i] <= 1'b0;
        end
      end
    end else if (cmd_i.wrule && wvalid) begin
      rule_v_q[item_q.rule_list][wslot] <= item_q.rule_enable;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wrule && wvalid) begin
      rule_addr_q[item_q.rule_list][wslot]  <= item_q.peer_address;
      rule_proto_q[item_q.rule_list][wslot] <= item_q.protocol_number;
      rule_port_q[item_q.rule_list][wslot]  <= item_q.dest_port;
    end
  end

  // rule counter memory, written once and read once per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.pick) begin
      rd_data_q <= rcnt_mem[rcnt_addr];
      rd_addr_q <= rcnt_addr;
    end
    if (cmd_i.inc) begin
      rcnt_mem[rd_addr_q] <= rinc;
    end else if (cmd_i.wrule && wvalid) begin
      rcnt_mem[rw_addr] <= 32'd0;
    end
  end

  // counter written-marks: unwritten counters read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rok_q   <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      if (cmd_i.pick) rd_ok_q <= rok_q[rcnt_addr];
      if (cmd_i.wrule && wvalid) rok_q[rw_addr] <= 1'b1;
    end
  end

  // peer table control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= PEER_DEPTH'(1);
      pok_q <= '0;
      prd_ok_q <= 1'b0;
      pidx_q <= '0;
      acnt_q <= '0;
      apick_q <= '0;
      best_q <= '0;
      for (int i = 0; i < PEER_DEPTH; i++) begin
        paddr_q[i]  <= (i == 0) ? LoopbackAddr : 32'd0;
        pstamp_q[i] <= 32'd0;
      end
    end else begin
      if (cmd_i.plook) begin
        pidx_q <= plook_idx;
        prd_ok_q <= pok_q[plook_idx];
      end
      if (cmd_i.pinc && (item_q.action == ActOutbound)) begin
        pstamp_q[pidx_q] <= item_q.now_seconds;
      end
      if (cmd_i.age_clr) begin
        acnt_q <= '0;
        apick_q <= '0;
        best_q <= '0;
      end
      if (cmd_i.age_step) begin
        if (acnt_q == '0 || acur > best_q) begin
          best_q <= acur;
          apick_q <= acnt_q;
        end
        acnt_q <= acnt_q + 1'b1;
      end
      if (cmd_i.insert) begin
        pv_q[ins_idx] <= 1'b1;
        pok_q[ins_idx] <= 1'b1;
        paddr_q[ins_idx] <= item_q.peer_address;
        pstamp_q[ins_idx] <= item_q.now_seconds;
      end
      if (cmd_i.clean) pv_q <= pv_q & ~pexp;
    end
  end

  // peer count memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.plook) begin
      sent_rd_q <= sent_mem[plook_idx];
      recv_rd_q <= recv_mem[plook_idx];
    end
    if (cmd_i.insert) begin
      sent_mem[ins_idx] <= 32'd1;
      recv_mem[ins_idx] <= 32'd0;
    end else if (cmd_i.pinc) begin
      if (item_q.action == ActOutbound) begin
        sent_mem[pidx_q] <= pinc_v;
      end else begin
        recv_mem[pidx_q] <= pinc_v;
      end
    end
  end

  // status
  assign sts_o.action    = item_q.action;
  assign sts_o.list      = list_q;
  assign sts_o.mvec_nz   = |mvec_q;
  assign sts_o.wild      = wild_q;
  assign sts_o.any       = any_q;
  assign sts_o.in_hit    = |pin;
  assign sts_o.out_found = |pfnd;
  assign sts_o.pfree     = ~&pv_q;
  assign sts_o.age_last  = (int'(acnt_q) == PEER_DEPTH - 1);

  assign result_o = res_q;

endmodule

FILE: design/stateful_packet_filter.sv
// Sequence from accept to result strobe: an unused action goes straight to the
// result and a rule write passes through the insert state. Inbound scans the
// allow and then the in-deny list, then looks up the peer; outbound scans the
// out-deny list, then looks up or inserts the peer, ageing a full table first.
// Throughput: one transfer at a time; the next start is taken in the cycle after
// the result strobe. Reset: rules invalid, counters zero, peer 0 loopback,
// window 60 seconds. Results are strobed one cycle; the receiver cannot stall.
// ---------------------------------------------------------------------------
// stateful_packet_filter: allow/deny lists with a connection table
// Top level: APB window register, controller and datapath.
// ---------------------------------------------------------------------------
module stateful_packet_filter #(
  parameter int unsigned RULE_DEPTH = sfp_pkg::RuleDepthDef,
  parameter int unsigned PEER_DEPTH = sfp_pkg::PeerDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  sfp_pkg::item_t   item_i,
  output logic             result_valid_o,
  output sfp_pkg::result_t result_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import sfp_pkg::*;

  logic [31:0] window_q;
  cmd_t        cmd;
  sts_t        sts;
  logic        ctrl_busy;

  // window register at byte address 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WindowReset;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      window_q <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : window_q;
  assign busy = ctrl_busy;

  sfp_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .start_action_i (item_i.action),
    .sts_i          (sts),
    .cmd_o          (cmd),
    .busy_o         (ctrl_busy),
    .done_o         (result_valid_o)
  );

  sfp_datapath #(
    .RULE_DEPTH (RULE_DEPTH),
    .PEER_DEPTH (PEER_DEPTH)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .window_i (window_q),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .result_o (result_o)
  );

endmodule
